@@ rtl/dgw_pkg.sv @@
// Package for the decimal glyph writer: widths, offsets, font table, state type.
`timescale 1ns / 1ps

package dgw_pkg;

   localparam int SLOT_COUNT  = 16;
   localparam int SLOT_WIDTH  = 4;
   localparam int VALUE_WIDTH = 16;
   localparam int ADDR_WIDTH  = 10;
   localparam int BYTE_WIDTH  = 6;
   localparam int DIGIT_WIDTH = 4;
   localparam int DIGIT_COUNT = 5;
   localparam int BCD_WIDTH   = DIGIT_WIDTH * DIGIT_COUNT;
   localparam int POS_WIDTH   = 6;
   localparam int COL_WIDTH   = 2;
   localparam int ITER_WIDTH  = 4;

   localparam logic [POS_WIDTH-1:0]  DIGIT_TOP  = 6'd32;
   localparam logic [POS_WIDTH-1:0]  CLEAR_LOW  = 6'd6;
   localparam logic [POS_WIDTH-1:0]  DIGIT_STEP = 6'd4;
   localparam logic [COL_WIDTH-1:0]  LAST_COL   = 2'd2;
   localparam logic [ADDR_WIDTH-1:0] ODD_SHIFT  = 10'd28;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_DIGIT,
      ST_CLEAR
   } state_type;

   typedef logic [BYTE_WIDTH-1:0] glyph_row_type [3];

   localparam glyph_row_type GLYPHS [10] = '{
      '{6'h3f, 6'h21, 6'h3f},
      '{6'h22, 6'h3f, 6'h20},
      '{6'h3d, 6'h25, 6'h27},
      '{6'h25, 6'h25, 6'h3f},
      '{6'h0f, 6'h08, 6'h3f},
      '{6'h27, 6'h25, 6'h3d},
      '{6'h3f, 6'h25, 6'h3d},
      '{6'h01, 6'h01, 6'h3f},
      '{6'h3f, 6'h25, 6'h3f},
      '{6'h2f, 6'h29, 6'h3f}
   };

   // Look up one font column; codes above nine map to a blank column
   function automatic logic [BYTE_WIDTH-1:0] glyph_column(
      input logic [DIGIT_WIDTH-1:0] digit,
      input logic [COL_WIDTH-1:0]   col
   );
      logic [BYTE_WIDTH-1:0] result;
      result = '0;
      if (digit <= 4'd9 && col <= LAST_COL) begin
         result = GLYPHS[digit][col];
      end
      return result;
   endfunction

endpackage

@@ rtl/dgw_bcd_conv.sv @@
// Bit-serial binary to BCD converter (shift and add-three, one bit per cycle).
`timescale 1ns / 1ps

module dgw_bcd_conv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [dgw_pkg::VALUE_WIDTH-1:0] value,
   output logic                          done,
   output logic [dgw_pkg::BCD_WIDTH-1:0] bcd
);

   logic [dgw_pkg::VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [dgw_pkg::BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [dgw_pkg::BCD_WIDTH-1:0]   adj;
   logic [dgw_pkg::ITER_WIDTH-1:0]  count_ff, count_in;
   logic                            run_ff, run_in;
   logic                            done_ff, done_in;

   // Add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < dgw_pkg::DIGIT_COUNT; i++) begin
         if (bcd_ff[i*dgw_pkg::DIGIT_WIDTH +: dgw_pkg::DIGIT_WIDTH] >= 4'd5) begin
            adj[i*dgw_pkg::DIGIT_WIDTH +: dgw_pkg::DIGIT_WIDTH] =
               bcd_ff[i*dgw_pkg::DIGIT_WIDTH +: dgw_pkg::DIGIT_WIDTH] + 4'd3;
         end else begin
            adj[i*dgw_pkg::DIGIT_WIDTH +: dgw_pkg::DIGIT_WIDTH] =
               bcd_ff[i*dgw_pkg::DIGIT_WIDTH +: dgw_pkg::DIGIT_WIDTH];
         end
      end
   end

   // Load, then shift one binary bit into the BCD word per cycle
   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (load) begin
         bin_in   = value;
         bcd_in   = '0;
         count_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         bin_in   = {bin_ff[dgw_pkg::VALUE_WIDTH-2:0], 1'b0};
         bcd_in   = {adj[dgw_pkg::BCD_WIDTH-2:0], bin_ff[dgw_pkg::VALUE_WIDTH-1]};
         count_in = count_ff + 1'b1;
         if (count_ff == '1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

@@ rtl/decimal_glyph_writer.sv @@
// Top level: renders a 16-bit value as decimal font columns into frame-buffer writes.
//
//   channel   ports                                        handshake
//   request   req_slot, req_number                         start & !busy
//   response  rsp_write_address, rsp_write_byte, rsp_last  rsp_valid, one per write
//
// An item goes through bit-serial BCD conversion and a handoff, then 30-n
// writes for n decimal digits at one write per cycle until busy drops. The
// conversion shift register and the single write port set how long that takes.
// A slot number of SLOT_COUNT or more is dropped at once. Reset clears the
// state machine and the strobe. Writes cannot be held off.
`timescale 1ns / 1ps

module decimal_glyph_writer #(
   parameter int SLOT_COUNT = dgw_pkg::SLOT_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dgw_pkg::SLOT_WIDTH-1:0]  req_slot,
   input  logic [dgw_pkg::VALUE_WIDTH-1:0] req_number,
   output logic                          rsp_valid,
   output logic [dgw_pkg::ADDR_WIDTH-1:0]  rsp_write_address,
   output logic [dgw_pkg::BYTE_WIDTH-1:0]  rsp_write_byte,
   output logic                          rsp_last
);

   dgw_pkg::state_type state_ff, state_in;

   logic [dgw_pkg::ADDR_WIDTH-1:0] base_ff, base_in;
   logic [dgw_pkg::POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [dgw_pkg::COL_WIDTH-1:0]  col_ff, col_in;
   logic [dgw_pkg::BCD_WIDTH-1:0]  digits_ff, digits_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [dgw_pkg::ADDR_WIDTH-1:0] rsp_address_ff, rsp_address_in;
   logic [dgw_pkg::BYTE_WIDTH-1:0] rsp_byte_ff, rsp_byte_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           accept;
   logic                           slot_ok;
   logic                           conv_done;
   logic [dgw_pkg::BCD_WIDTH-1:0]  conv_bcd;
   logic [dgw_pkg::POS_WIDTH-1:0]  offset;

   assign busy    = (state_ff != dgw_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign slot_ok = ({1'b0, req_slot} < (dgw_pkg::SLOT_WIDTH+1)'(SLOT_COUNT));
   assign offset  = pos_ff + {{(dgw_pkg::POS_WIDTH-dgw_pkg::COL_WIDTH){1'b0}}, col_ff};

   dgw_bcd_conv u_conv (
      .clock (clock),
      .reset (reset),
      .load  (accept && slot_ok),
      .value (req_number),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   // Next state, write generation and digit/position stepping
   always_comb begin
      state_in       = state_ff;
      base_in        = base_ff;
      pos_in         = pos_ff;
      col_in         = col_ff;
      digits_in      = digits_ff;
      rsp_valid_in   = 1'b0;
      rsp_address_in = rsp_address_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = 1'b0;
      case (state_ff)
         dgw_pkg::ST_IDLE: begin
            if (accept && slot_ok) begin
               base_in = {req_slot, 6'b0} + (req_slot[0] ? dgw_pkg::ODD_SHIFT : '0);
               state_in = dgw_pkg::ST_CONVERT;
            end
         end
         dgw_pkg::ST_CONVERT: begin
            if (conv_done) begin
               digits_in = conv_bcd;
               pos_in    = dgw_pkg::DIGIT_TOP;
               col_in    = '0;
               state_in  = dgw_pkg::ST_DIGIT;
            end
         end
         dgw_pkg::ST_DIGIT: begin
            rsp_valid_in   = 1'b1;
            rsp_address_in = base_ff + {{(dgw_pkg::ADDR_WIDTH-dgw_pkg::POS_WIDTH){1'b0}}, offset};
            rsp_byte_in    = dgw_pkg::glyph_column(digits_ff[dgw_pkg::DIGIT_WIDTH-1:0], col_ff);
            if (col_ff == dgw_pkg::LAST_COL) begin
               col_in    = '0;
               digits_in = digits_ff >> dgw_pkg::DIGIT_WIDTH;
               // Drop to the clear run once no higher digit remains
               if (digits_ff[dgw_pkg::BCD_WIDTH-1:dgw_pkg::DIGIT_WIDTH] == '0) begin
                  pos_in   = pos_ff - 1'b1;
                  state_in = dgw_pkg::ST_CLEAR;
               end else begin
                  pos_in = pos_ff - dgw_pkg::DIGIT_STEP;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         dgw_pkg::ST_CLEAR: begin
            rsp_valid_in   = 1'b1;
            rsp_address_in = base_ff + {{(dgw_pkg::ADDR_WIDTH-dgw_pkg::POS_WIDTH){1'b0}}, pos_ff};
            rsp_byte_in    = '0;
            pos_in         = pos_ff - 1'b1;
            if (pos_ff == dgw_pkg::CLEAR_LOW) begin
               rsp_last_in = 1'b1;
               state_in    = dgw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dgw_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dgw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      base_ff        <= base_in;
      pos_ff         <= pos_in;
      col_ff         <= col_in;
      digits_ff      <= digits_in;
      rsp_address_ff <= rsp_address_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_address_ff;
   assign rsp_write_byte    = rsp_byte_ff;
   assign rsp_last          = rsp_valid_ff && rsp_last_ff;

   // The final beat of an item shows only once the machine is idle again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("last beat while still busy");

   // An accepted item in range starts conversion
   a_accept_convert: assert property (@(posedge clock) disable iff (reset)
      accept && slot_ok |=> state_ff == dgw_pkg::ST_CONVERT)
      else $error("accepted item did not start conversion");

   // The clear run never goes below its low offset
   a_clear_floor: assert property (@(posedge clock) disable iff (reset)
      state_ff == dgw_pkg::ST_CLEAR |-> pos_ff >= dgw_pkg::CLEAR_LOW)
      else $error("clear position below floor");

   // Emitted digits are decimal
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == dgw_pkg::ST_DIGIT |-> digits_ff[dgw_pkg::DIGIT_WIDTH-1:0] <= 4'd9)
      else $error("digit out of decimal range");

endmodule

@@ bench/decimal_glyph_writer_test.sv @@
// Self-checking bench for the decimal glyph writer: random and directed values, scored writes.
`timescale 1ns / 1ps

module decimal_glyph_writer_test;

   localparam int CLEAR_FLOOR    = 6;
   localparam int TOP_OFFSET     = 32;
   localparam int ODD_SLOT_SKEW  = 28;
   localparam int DRAIN_CYCLES   = 60;
   localparam int LIMIT_CYCLES   = 100000;
   localparam int PHASE_ITEMS    = 55;

   // Three columns per digit, digits 0 to 9
   localparam logic [dgw_pkg::BYTE_WIDTH-1:0] FONT_COLUMNS [30] = '{
      6'h3f, 6'h21, 6'h3f,
      6'h22, 6'h3f, 6'h20,
      6'h3d, 6'h25, 6'h27,
      6'h25, 6'h25, 6'h3f,
      6'h0f, 6'h08, 6'h3f,
      6'h27, 6'h25, 6'h3d,
      6'h3f, 6'h25, 6'h3d,
      6'h01, 6'h01, 6'h3f,
      6'h3f, 6'h25, 6'h3f,
      6'h2f, 6'h29, 6'h3f
   };

   // Directed items: zero, full scale, every digit count, every glyph, both slot parities
   localparam logic [dgw_pkg::SLOT_WIDTH-1:0] DIR_SLOTS [16] = '{
      4'd0, 4'd15, 4'd1, 4'd14, 4'd3, 4'd2, 4'd5, 4'd8,
      4'd9, 4'd6, 4'd7, 4'd10, 4'd11, 4'd12, 4'd13, 4'd4
   };
   localparam logic [dgw_pkg::VALUE_WIDTH-1:0] DIR_NUMBERS [16] = '{
      16'd0, 16'd65535, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
      16'd9999, 16'd10000, 16'd12345, 16'd54321, 16'd9876, 16'd65530, 16'd8, 16'd40607
   };

   typedef struct packed {
      logic [dgw_pkg::ADDR_WIDTH-1:0] address;
      logic [dgw_pkg::BYTE_WIDTH-1:0] pattern;
      logic                           last;
   } fb_write_type;

   // Expected frame-buffer writes, oldest first
   class glyph_write_tracker;
      fb_write_type pending_writes[$];
      int unsigned  fail_count = 0;

      // Render one accepted number into the writes it must produce
      function void note_number(logic [dgw_pkg::SLOT_WIDTH-1:0] slot,
                                logic [dgw_pkg::VALUE_WIDTH-1:0] number);
         int unsigned  base;
         int unsigned  rest;
         int           pos;
         int           digits;
         int           total;
         int           k;
         fb_write_type w;
         if (slot >= dgw_pkg::SLOT_COUNT) begin
            return;
         end
         base = slot * 64 + (slot[0] ? ODD_SLOT_SKEW : 0);
         digits = 0;
         rest = number;
         do begin
            digits++;
            rest = rest / 10;
         end while (rest != 0);
         total = 30 - digits;
         k = 0;
         rest = number;
         pos = TOP_OFFSET;
         // Font columns, least significant digit at the top offset
         for (int d = 0; d < digits; d++) begin
            for (int c = 0; c < 3; c++) begin
               w.address = (dgw_pkg::ADDR_WIDTH)'(base + pos + c);
               w.pattern = FONT_COLUMNS[(rest % 10) * 3 + c];
               w.last    = (k == total - 1);
               pending_writes.push_back(w);
               k++;
            end
            rest = rest / 10;
            pos = pos - 4;
         end
         // Clear from the offset just below the leading digit down to the floor
         for (int p = pos + 3; p >= CLEAR_FLOOR; p--) begin
            w.address = (dgw_pkg::ADDR_WIDTH)'(base + p);
            w.pattern = '0;
            w.last    = (k == total - 1);
            pending_writes.push_back(w);
            k++;
         end
      endfunction

      // Score one write beat against the oldest expectation
      function void check_write(logic [dgw_pkg::ADDR_WIDTH-1:0] address,
                                logic [dgw_pkg::BYTE_WIDTH-1:0] pattern,
                                logic last);
         fb_write_type w;
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected write address %0d pattern %h last %0d",
                     $time, address, pattern, last);
            fail_count++;
            return;
         end
         w = pending_writes.pop_front();
         if (address !== w.address) begin
            $display("%0t: address expected %0d actual %0d", $time, w.address, address);
            fail_count++;
         end
         if (pattern !== w.pattern) begin
            $display("%0t: pattern at %0d expected %h actual %h",
                     $time, w.address, w.pattern, pattern);
            fail_count++;
         end
         if (last !== w.last) begin
            $display("%0t: last at %0d expected %0d actual %0d",
                     $time, w.address, w.last, last);
            fail_count++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [dgw_pkg::SLOT_WIDTH-1:0]  req_slot;
   logic [dgw_pkg::VALUE_WIDTH-1:0] req_number;
   logic                            rsp_valid;
   logic [dgw_pkg::ADDR_WIDTH-1:0]  rsp_write_address;
   logic [dgw_pkg::BYTE_WIDTH-1:0]  rsp_write_byte;
   logic                            rsp_last;

   glyph_write_tracker board = new();
   int unsigned        cycle_count = 0;

   decimal_glyph_writer dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_slot          (req_slot),
      .req_number        (req_number),
      .rsp_valid         (rsp_valid),
      .rsp_write_address (rsp_write_address),
      .rsp_write_byte    (rsp_write_byte),
      .rsp_last          (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // Score every write beat
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_write(rsp_write_address, rsp_write_byte, rsp_last);
      end
   end

   // Present one number; enter and leave just after a falling edge
   task automatic send_number(input logic [dgw_pkg::SLOT_WIDTH-1:0] slot,
                              input logic [dgw_pkg::VALUE_WIDTH-1:0] number,
                              input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start      <= 1'b1;
      req_slot   <= slot;
      req_number <= number;
      forever begin
         @(posedge clock);
         if (!busy) begin
            break;
         end
      end
      board.note_number(slot, number);
      @(negedge clock);
   endtask

   // Hold off until every expected write has come and the block is free
   task automatic wait_for_drain();
      start <= 1'b0;
      while (board.pending_writes.size() != 0 || busy) begin
         @(negedge clock);
      end
   endtask

   // Spread values over all digit counts, with some fully random words
   function automatic logic [dgw_pkg::VALUE_WIDTH-1:0] pick_number();
      logic [dgw_pkg::VALUE_WIDTH-1:0] v;
      case ($urandom_range(5))
         0: v = (dgw_pkg::VALUE_WIDTH)'($urandom_range(9));
         1: v = (dgw_pkg::VALUE_WIDTH)'($urandom_range(99, 10));
         2: v = (dgw_pkg::VALUE_WIDTH)'($urandom_range(999, 100));
         3: v = (dgw_pkg::VALUE_WIDTH)'($urandom_range(9999, 1000));
         4: v = (dgw_pkg::VALUE_WIDTH)'($urandom_range(65535, 10000));
         default: v = (dgw_pkg::VALUE_WIDTH)'($urandom);
      endcase
      return v;
   endfunction

   int idle_by_phase [4] = '{0, 78, 32, 0};

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_slot   = '0;
      req_number = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items first
      foreach (DIR_NUMBERS[i]) begin
         send_number(DIR_SLOTS[i], DIR_NUMBERS[i], 0);
      end
      wait_for_drain();

      // Random phases, drained in between
      foreach (idle_by_phase[p]) begin
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_number((dgw_pkg::SLOT_WIDTH)'($urandom_range(dgw_pkg::SLOT_COUNT - 1)),
                        pick_number(), idle_by_phase[p]);
         end
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fail_count == 0 && board.pending_writes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
